@@ rtl/rse_pkg.sv @@
package rse_pkg;

    // Sizing of the evaluator.
    localparam int STACK_DEPTH = 16;
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 3;

    // Token queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Divider iteration count: one quotient bit per cycle.
    localparam int DIV_STEPS   = DATA_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

    // Bias added to a negative product so the shift truncates toward zero.
    localparam logic signed [2*DATA_W-1:0] MUL_ROUND =
        (64'sd1 <<< FRAC_BITS) - 64'sd1;

    // Command codes on the input channel.
    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_END  = 3'd5;

    // Classified operation carried through the queue.
    typedef enum logic [2:0] {
        OP_PUSH,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_END
    } op_t;

    // Status codes on the result channel.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_UNDERFLOW = 3'd1,
        STAT_DIVZERO   = 3'd2,
        STAT_EMPTY     = 3'd3,
        STAT_EXTRA     = 3'd4,
        STAT_OVERFLOW  = 3'd5
    } status_t;

    // Sequencer states of the back end.
    typedef enum logic [2:0] {
        S_IDLE,
        S_FETCH,
        S_MULSH,
        S_DIV,
        S_SAT,
        S_OUT
    } state_t;

    // One queued token.
    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] operand;
    } token_t;

endpackage

@@ rtl/rpn_stack_evaluator_top.sv @@
// Channel   Direction  Handshake           Payload
// s_        input      s_tvalid/s_tready   s_tdata operand, s_tuser command
// m_        output     m_tvalid/m_tready   m_tdata value, m_tuser status
//
// The back end handles a push in idle; add and subtract pass through fetch
// and saturate, multiply also through shift, and divide also through the
// 32-step restoring divider. An end token's result is held until transfer.
// A two-entry token queue lets the input side keep taking transfers, until
// it is full, while the back end computes or the result waits.
// Reset clears the stack count, the held error and the queue; the stack
// memory is not cleared, since only written entries are ever read.
module rpn_stack_evaluator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [rse_pkg::DATA_W-1:0]    s_tdata,  // [31:0] operand
    input  logic [rse_pkg::CMD_W-1:0]     s_tuser,  // [2:0] command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rse_pkg::DATA_W-1:0]    m_tdata,  // [31:0] value
    output logic [rse_pkg::STATUS_W-1:0]  m_tuser   // [2:0] status
);

    logic            q_wr_valid, q_wr_ready;
    rse_pkg::token_t q_wr_entry;
    logic            q_rd_valid, q_rd_ready;
    rse_pkg::token_t q_rd_entry;

    // Token decode on the input side.
    rse_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_wr_valid (q_wr_valid),
        .q_wr_ready (q_wr_ready),
        .q_wr_entry (q_wr_entry)
    );

    // Decoupling queue.
    rse_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (q_wr_valid),
        .wr_ready (q_wr_ready),
        .wr_entry (q_wr_entry),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_entry (q_rd_entry)
    );

    // Stack machine and arithmetic.
    rse_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_rd_valid (q_rd_valid),
        .q_rd_ready (q_rd_ready),
        .q_rd_entry (q_rd_entry),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

@@ rtl/rse_ram.sv @@
module rse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/rse_front.sv @@
module rse_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [rse_pkg::DATA_W-1:0]  s_tdata,
    input  logic [rse_pkg::CMD_W-1:0]   s_tuser,
    output logic                        q_wr_valid,
    input  logic                        q_wr_ready,
    output rse_pkg::token_t             q_wr_entry
);

    logic               known;
    rse_pkg::op_t       op;

    // Decode the command; unused codes are taken and discarded.
    always_comb begin
        known = 1'b1;
        op    = rse_pkg::OP_PUSH;
        unique case (s_tuser)
            rse_pkg::CMD_PUSH: op = rse_pkg::OP_PUSH;
            rse_pkg::CMD_ADD:  op = rse_pkg::OP_ADD;
            rse_pkg::CMD_SUB:  op = rse_pkg::OP_SUB;
            rse_pkg::CMD_MUL:  op = rse_pkg::OP_MUL;
            rse_pkg::CMD_DIV:  op = rse_pkg::OP_DIV;
            rse_pkg::CMD_END:  op = rse_pkg::OP_END;
            default:           known = 1'b0;
        endcase
    end

    assign s_tready           = q_wr_ready;
    assign q_wr_valid         = s_tvalid && known;
    assign q_wr_entry.op      = op;
    assign q_wr_entry.operand = s_tdata;

endmodule

@@ rtl/rse_queue.sv @@
module rse_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  rse_pkg::token_t wr_entry,
    output logic            rd_valid,
    input  logic            rd_ready,
    output rse_pkg::token_t rd_entry
);

    rse_pkg::token_t                  slot_reg [rse_pkg::QUEUE_DEPTH];
    logic [rse_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [rse_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [rse_pkg::QCNT_W-1:0]       fill_reg, fill_next;
    logic                             do_wr, do_rd;

    assign wr_ready = (fill_reg != rse_pkg::QCNT_W'(rse_pkg::QUEUE_DEPTH));
    assign rd_valid = (fill_reg != '0);
    assign rd_entry = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // Pointer and fill bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == rse_pkg::QPTR_W'(rse_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + rse_pkg::QPTR_W'(1);
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == rse_pkg::QPTR_W'(rse_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + rse_pkg::QPTR_W'(1);
        end
        if (do_wr && !do_rd) begin
            fill_next = fill_reg + rse_pkg::QCNT_W'(1);
        end else if (do_rd && !do_wr) begin
            fill_next = fill_reg - rse_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Token storage.
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

@@ rtl/rse_div.sv @@
module rse_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic signed [rse_pkg::DATA_W-1:0]   left,
    input  logic signed [rse_pkg::DATA_W-1:0]   right,
    output logic                                done,
    output logic signed [2*rse_pkg::DATA_W-1:0] result
);

    localparam int W = rse_pkg::DATA_W;

    logic [W-1:0]                   rem_reg, rem_next;
    logic [W-1:0]                   quo_reg, quo_next;
    logic [W-1:0]                   absr_reg, absr_next;
    logic                           neg_reg, neg_next;
    logic                           ovf_reg, ovf_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [rse_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;

    logic [W-1:0]                   absl, absr;
    logic [2*W-1:0]                 dvd;
    logic [W:0]                     shifted;
    logic                           ge;
    logic signed [2*W-1:0]          mag;

    // Magnitudes of the operands and the scaled dividend.
    assign absl = left[W-1]  ? (W'(0) - W'(left))  : W'(left);
    assign absr = right[W-1] ? (W'(0) - W'(right)) : W'(right);
    assign dvd  = {{W{1'b0}}, absl} << rse_pkg::FRAC_BITS;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    assign shifted = {rem_reg, quo_reg[W-1]};
    assign ge      = (shifted >= {1'b0, absr_reg});

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        absr_next = absr_reg;
        neg_next  = neg_reg;
        ovf_next  = ovf_reg;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start) begin
            // The upper half of the dividend is below the divisor unless the
            // quotient needs more than one word; then it saturates anyway.
            rem_next  = dvd[2*W-1:W];
            quo_next  = dvd[W-1:0];
            absr_next = absr;
            neg_next  = left[W-1] ^ right[W-1];
            ovf_next  = (dvd[2*W-1:W] >= absr);
            busy_next = 1'b1;
            cnt_next  = rse_pkg::DIV_CNT_W'(rse_pkg::DIV_STEPS);
        end else if (busy_reg) begin
            rem_next = ge ? W'(shifted - {1'b0, absr_reg}) : shifted[W-1:0];
            quo_next = {quo_reg[W-2:0], ge};
            cnt_next = cnt_reg - rse_pkg::DIV_CNT_W'(1);
            if (cnt_reg == rse_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        absr_reg <= absr_next;
        neg_reg  <= neg_next;
        ovf_reg  <= ovf_next;
    end

    // Signed quotient; an oversized magnitude is pushed past the word range.
    assign mag    = ovf_reg ? ((2*W)'(1) <<< W) : {{W{1'b0}}, quo_reg};
    assign result = neg_reg ? -mag : mag;
    assign done   = done_reg;

endmodule

@@ rtl/rse_back.sv @@
module rse_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_rd_valid,
    output logic                          q_rd_ready,
    input  rse_pkg::token_t               q_rd_entry,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rse_pkg::DATA_W-1:0]    m_tdata,
    output logic [rse_pkg::STATUS_W-1:0]  m_tuser
);

    localparam int W = rse_pkg::DATA_W;

    rse_pkg::state_t                 state_reg, state_next;
    logic [rse_pkg::CNT_W-1:0]       count_reg, count_next;
    rse_pkg::status_t                err_reg, err_next;
    logic signed [W-1:0]             tos_reg, tos_next;
    rse_pkg::op_t                    op_reg, op_next;
    logic signed [2*W-1:0]           prod_reg, prod_next;
    logic signed [2*W-1:0]           wide_reg, wide_next;
    logic [W-1:0]                    out_value_reg, out_value_next;
    rse_pkg::status_t                out_status_reg, out_status_next;

    logic                            ram_we;
    logic [rse_pkg::ADDR_W-1:0]      ram_waddr, ram_raddr;
    logic signed [W-1:0]             ram_rdata;
    logic                            div_start, div_done;
    logic signed [2*W-1:0]           div_result;
    logic signed [2*W-1:0]           mul_bias;
    logic                            sat_hi, sat_lo;
    logic signed [W-1:0]             sat_value;
    rse_pkg::status_t                end_status;

    // Keeps the first error until the end token.
    function automatic rse_pkg::status_t keep_first(input rse_pkg::status_t held,
                                                    input rse_pkg::status_t code);
        return (held == rse_pkg::STAT_OK) ? code : held;
    endfunction

    // Entries below the top of stack; the top itself lives in tos_reg.
    rse_ram #(
        .WIDTH(W),
        .DEPTH(rse_pkg::STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (tos_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    rse_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .left    (ram_rdata),
        .right   (tos_reg),
        .done    (div_done),
        .result  (div_result)
    );

    assign ram_waddr = rse_pkg::ADDR_W'(count_reg - rse_pkg::CNT_W'(1));
    assign ram_raddr = rse_pkg::ADDR_W'(count_reg - rse_pkg::CNT_W'(2));

    // Saturation of a wide intermediate to one word.
    assign sat_hi    = !wide_reg[2*W-1] && (|wide_reg[2*W-2:W-1]);
    assign sat_lo    = wide_reg[2*W-1] && !(&wide_reg[2*W-2:W-1]);
    assign sat_value = sat_hi ? {1'b0, {(W-1){1'b1}}} :
                       sat_lo ? {1'b1, {(W-1){1'b0}}} : wide_reg[W-1:0];

    assign mul_bias  = prod_reg[2*W-1] ? rse_pkg::MUL_ROUND : '0;

    // Status reported by an end token.
    always_comb begin
        if (err_reg != rse_pkg::STAT_OK) begin
            end_status = err_reg;
        end else if (count_reg == '0) begin
            end_status = rse_pkg::STAT_EMPTY;
        end else if (count_reg > rse_pkg::CNT_W'(1)) begin
            end_status = rse_pkg::STAT_EXTRA;
        end else begin
            end_status = rse_pkg::STAT_OK;
        end
    end

    // Sequencer: next state and datapath controls.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        err_next        = err_reg;
        tos_next        = tos_reg;
        op_next         = op_reg;
        prod_next       = prod_reg;
        wide_next       = wide_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        q_rd_ready      = 1'b0;
        ram_we          = 1'b0;
        div_start       = 1'b0;
        unique case (state_reg)
            rse_pkg::S_IDLE: begin
                q_rd_ready = 1'b1;
                if (q_rd_valid) begin
                    unique case (q_rd_entry.op) inside
                        rse_pkg::OP_PUSH: begin
                            if (count_reg == rse_pkg::CNT_W'(rse_pkg::STACK_DEPTH)) begin
                                err_next = keep_first(err_reg, rse_pkg::STAT_OVERFLOW);
                            end else begin
                                ram_we     = (count_reg != '0);
                                tos_next   = q_rd_entry.operand;
                                count_next = count_reg + rse_pkg::CNT_W'(1);
                            end
                        end
                        rse_pkg::OP_ADD, rse_pkg::OP_SUB, rse_pkg::OP_MUL,
                        rse_pkg::OP_DIV: begin
                            if (count_reg < rse_pkg::CNT_W'(2)) begin
                                err_next = keep_first(err_reg, rse_pkg::STAT_UNDERFLOW);
                            end else if (q_rd_entry.op == rse_pkg::OP_DIV &&
                                         tos_reg == '0) begin
                                err_next = keep_first(err_reg, rse_pkg::STAT_DIVZERO);
                            end else begin
                                op_next    = q_rd_entry.op;
                                state_next = rse_pkg::S_FETCH;
                            end
                        end
                        rse_pkg::OP_END: begin
                            out_status_next = end_status;
                            out_value_next  = (end_status == rse_pkg::STAT_OK) ?
                                              tos_reg : '0;
                            count_next      = '0;
                            err_next        = rse_pkg::STAT_OK;
                            state_next      = rse_pkg::S_OUT;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rse_pkg::S_FETCH: begin
                // Left operand arrives from the stack memory this cycle.
                unique case (op_reg) inside
                    rse_pkg::OP_ADD: begin
                        wide_next  = (2*W)'(ram_rdata) + (2*W)'(tos_reg);
                        state_next = rse_pkg::S_SAT;
                    end
                    rse_pkg::OP_SUB: begin
                        wide_next  = (2*W)'(ram_rdata) - (2*W)'(tos_reg);
                        state_next = rse_pkg::S_SAT;
                    end
                    rse_pkg::OP_MUL: begin
                        prod_next  = ram_rdata * tos_reg;
                        state_next = rse_pkg::S_MULSH;
                    end
                    default: begin
                        div_start  = 1'b1;
                        state_next = rse_pkg::S_DIV;
                    end
                endcase
            end
            rse_pkg::S_MULSH: begin
                wide_next  = (prod_reg + mul_bias) >>> rse_pkg::FRAC_BITS;
                state_next = rse_pkg::S_SAT;
            end
            rse_pkg::S_DIV: begin
                if (div_done) begin
                    wide_next  = div_result;
                    state_next = rse_pkg::S_SAT;
                end
            end
            rse_pkg::S_SAT: begin
                tos_next   = sat_value;
                count_next = count_reg - rse_pkg::CNT_W'(1);
                state_next = rse_pkg::S_IDLE;
            end
            rse_pkg::S_OUT: begin
                if (m_tready) begin
                    state_next = rse_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = rse_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rse_pkg::S_IDLE;
            count_reg <= '0;
            err_reg   <= rse_pkg::STAT_OK;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        tos_reg        <= tos_next;
        op_reg         <= op_next;
        prod_reg       <= prod_next;
        wide_reg       <= wide_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = (state_reg == rse_pkg::S_OUT);
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

endmodule

@@ rtl/rse_checker.sv @@
module rse_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [rse_pkg::DATA_W-1:0]    s_tdata,
    input logic [rse_pkg::CMD_W-1:0]     s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [rse_pkg::DATA_W-1:0]    m_tdata,
    input logic [rse_pkg::STATUS_W-1:0]  m_tuser
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A failed expression reports a zero value.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != rse_pkg::STAT_OK) |-> (m_tdata == '0))
        else $error("nonzero value with error status");

    // Only defined status codes appear.
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser <= rse_pkg::STAT_OVERFLOW))
        else $error("undefined status code");

    // No result right after reset.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result presented after reset");

    // An accepted result is never followed in the next cycle by another one,
    // since each result needs its own end token to be taken first.
    a_one_per_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> !m_tvalid)
        else $error("back-to-back results");

endmodule

bind rpn_stack_evaluator_top rse_checker u_checker (.*);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

    // Command codes the evaluator must ignore.
    localparam logic [rse_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [rse_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

    // Q16.16 constants used by the directed expressions.
    localparam logic [rse_pkg::DATA_W-1:0] FX_MAX      = 32'h7FFF_FFFF;
    localparam logic [rse_pkg::DATA_W-1:0] FX_MIN      = 32'h8000_0000;
    localparam logic [rse_pkg::DATA_W-1:0] FX_ONE      = 32'h0001_0000;
    localparam logic [rse_pkg::DATA_W-1:0] FX_NEG_1P5  = 32'hFFFE_8000;
    localparam logic [rse_pkg::DATA_W-1:0] FX_2P25     = 32'h0002_4000;
    localparam logic [rse_pkg::DATA_W-1:0] FX_7        = 32'h0007_0000;
    localparam logic [rse_pkg::DATA_W-1:0] FX_NEG_2    = 32'hFFFE_0000;

    localparam int TOKEN_TARGET  = 1850;
    localparam int LONG_HOLD     = 400;
    localparam int QUIET_LIMIT   = 3000;
    localparam int TAIL_CYCLES   = 60;
    localparam int REPORT_LIMIT  = 40;

    typedef struct {
        logic [rse_pkg::CMD_W-1:0]  cmd;
        logic [rse_pkg::DATA_W-1:0] operand;
        bit                         drain_first;
    } token_item_t;

    typedef struct {
        logic [rse_pkg::DATA_W-1:0] value;
        rse_pkg::status_t           status;
    } eval_result_t;

    logic                          aclk = 1'b0;
    logic                          aresetn = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [rse_pkg::DATA_W-1:0]    s_tdata = '0;
    logic [rse_pkg::CMD_W-1:0]     s_tuser = rse_pkg::CMD_PUSH;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [rse_pkg::DATA_W-1:0]    m_tdata;
    logic [rse_pkg::STATUS_W-1:0]  m_tuser;

    // Predictor state: a private copy of the evaluator's stack and held error.
    logic signed [rse_pkg::DATA_W-1:0] stack_copy [rse_pkg::STACK_DEPTH];
    int                                stack_fill = 0;
    rse_pkg::status_t                  first_error = rse_pkg::STAT_OK;

    token_item_t  pending_tokens[$];
    eval_result_t results_due[$];

    int  queued_tokens = 0;
    int  expr_count = 0;
    int  err_count = 0;
    int  results_seen = 0;
    int  idle_cycles = 0;
    logic token_taken = 1'b0;

    int  burst_left = 0;
    int  gap_left = 0;
    int  rx_mode = 0;
    int  rx_run = 0;
    int  rx_phase = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  send_now;
    bit  ready_now;

    rpn_stack_evaluator_top u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] operand
        .s_tuser  (s_tuser),   // [2:0] command
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] value
        .m_tuser  (m_tuser)    // [2:0] status
    );

    always #5 aclk = ~aclk;

    // Clamp a wide intermediate to the 32-bit fixed-point range.
    function automatic logic signed [rse_pkg::DATA_W-1:0] fx_saturate(input longint wide);
        if (wide > longint'(32'sh7FFF_FFFF))
            return 32'sh7FFF_FFFF;
        if (wide < -longint'(64'sh8000_0000))
            return 32'sh8000_0000;
        return wide[rse_pkg::DATA_W-1:0];
    endfunction

    function automatic void note_error(input rse_pkg::status_t code);
        if (first_error == rse_pkg::STAT_OK)
            first_error = code;
    endfunction

    // Apply one accepted token to the predictor; an end token yields a result.
    function automatic void eval_token(input logic [rse_pkg::CMD_W-1:0] cmd,
                                       input logic [rse_pkg::DATA_W-1:0] operand);
        longint       lhs;
        longint       rhs;
        longint       wide;
        longint       scale;
        bit           done;
        eval_result_t res;
        scale = longint'(1) <<< rse_pkg::FRAC_BITS;
        done = 1'b1;
        wide = 0;
        case (cmd) inside
            rse_pkg::CMD_PUSH: begin
                if (stack_fill >= rse_pkg::STACK_DEPTH)
                    note_error(rse_pkg::STAT_OVERFLOW);
                else begin
                    stack_copy[stack_fill] = operand;
                    stack_fill++;
                end
            end
            rse_pkg::CMD_ADD, rse_pkg::CMD_SUB, rse_pkg::CMD_MUL, rse_pkg::CMD_DIV: begin
                if (stack_fill < 2) begin
                    note_error(rse_pkg::STAT_UNDERFLOW);
                end else begin
                    rhs = stack_copy[stack_fill-1];
                    lhs = stack_copy[stack_fill-2];
                    case (cmd)
                        rse_pkg::CMD_ADD: wide = lhs + rhs;
                        rse_pkg::CMD_SUB: wide = lhs - rhs;
                        rse_pkg::CMD_MUL: wide = (lhs * rhs) / scale;
                        default: begin
                            if (rhs == 0) begin
                                note_error(rse_pkg::STAT_DIVZERO);
                                done = 1'b0;
                            end else
                                wide = (lhs * scale) / rhs;
                        end
                    endcase
                    if (done) begin
                        stack_fill--;
                        stack_copy[stack_fill-1] = fx_saturate(wide);
                    end
                end
            end
            rse_pkg::CMD_END: begin
                res.status = first_error;
                res.value = '0;
                if (res.status == rse_pkg::STAT_OK) begin
                    if (stack_fill == 0)
                        res.status = rse_pkg::STAT_EMPTY;
                    else if (stack_fill > 1)
                        res.status = rse_pkg::STAT_EXTRA;
                    else
                        res.value = stack_copy[0];
                end
                results_due.push_back(res);
                stack_fill = 0;
                first_error = rse_pkg::STAT_OK;
            end
            default: ;
        endcase
    endfunction

    // Stimulus building blocks.
    task automatic add_token(input logic [rse_pkg::CMD_W-1:0] cmd,
                             input logic [rse_pkg::DATA_W-1:0] operand,
                             input bit drain_first = 1'b0);
        token_item_t t;
        t.cmd = cmd;
        t.operand = operand;
        t.drain_first = drain_first;
        pending_tokens.push_back(t);
        if (cmd != CMD_SPARE_LO && cmd != CMD_SPARE_HI)
            queued_tokens++;
    endtask

    function automatic logic [rse_pkg::DATA_W-1:0] pick_operand();
        int small_val;
        case ($urandom_range(0, 11)) inside
            0: return FX_MAX;
            1: return FX_MIN;
            2: return '0;
            3: return ($urandom_range(0, 1) == 0) ? FX_ONE : -FX_ONE;
            4, 5: return $urandom;
            default: begin
                // Values within about +-8.0 keep products and quotients in range.
                small_val = int'($urandom_range(0, 32'hF_FFFF)) - 32'h8_0000;
                return small_val;
            end
        endcase
    endfunction

    function automatic logic [rse_pkg::CMD_W-1:0] pick_operator();
        case ($urandom_range(0, 3))
            0: return rse_pkg::CMD_ADD;
            1: return rse_pkg::CMD_SUB;
            2: return rse_pkg::CMD_MUL;
            default: return rse_pkg::CMD_DIV;
        endcase
    endfunction

    // A well-formed postfix expression with n_vals operands, then an end token.
    task automatic add_expression(input int n_vals, input bit drain_first);
        int pushes_left;
        int ops_left;
        int depth;
        bit first;
        bit pick_op;
        pushes_left = n_vals;
        ops_left = n_vals - 1;
        depth = 0;
        first = drain_first;
        while (pushes_left > 0 || ops_left > 0) begin
            pick_op = (pushes_left == 0) || (depth >= rse_pkg::STACK_DEPTH) ||
                      ($urandom_range(0, 1) == 1);
            if (depth >= 2 && ops_left > 0 && pick_op) begin
                add_token(pick_operator(), $urandom, first);
                ops_left--;
                depth--;
            end else begin
                add_token(rse_pkg::CMD_PUSH, pick_operand(), first);
                pushes_left--;
                depth++;
            end
            first = 1'b0;
        end
        add_token(rse_pkg::CMD_END, $urandom);
    endtask

    // Broken or noisy token runs: random commands, stack overflow, underflow, leftovers, lone end tokens.
    task automatic add_noise();
        int n;
        case ($urandom_range(0, 3))
            0: begin
                n = $urandom_range(1, 8);
                repeat (n) add_token(rse_pkg::CMD_W'($urandom_range(0, 7)), pick_operand());
                add_token(rse_pkg::CMD_END, $urandom);
            end
            1: begin
                n = $urandom_range(rse_pkg::STACK_DEPTH + 1, rse_pkg::STACK_DEPTH + 3);
                repeat (n) add_token(rse_pkg::CMD_PUSH, pick_operand());
                n = $urandom_range(0, 4);
                repeat (n) add_token(pick_operator(), $urandom);
                add_token(rse_pkg::CMD_END, $urandom);
            end
            2: begin
                n = $urandom_range(2, 6);
                repeat (n) add_token(rse_pkg::CMD_PUSH, pick_operand());
                n = $urandom_range(0, n + 1);
                repeat (n) add_token(pick_operator(), $urandom);
                add_token(rse_pkg::CMD_END, $urandom);
            end
            default: begin
                add_token(rse_pkg::CMD_END, $urandom);
                if ($urandom_range(0, 1) == 1)
                    add_token(rse_pkg::CMD_END, $urandom);
            end
        endcase
    endtask

    task automatic build_stimulus();
        int n_vals;
        // Empty stack at the end token.
        add_token(rse_pkg::CMD_END, '0);
        // Saturation at both ends of the range.
        add_token(rse_pkg::CMD_PUSH, FX_MAX);
        add_token(rse_pkg::CMD_PUSH, FX_MAX);
        add_token(rse_pkg::CMD_ADD, '0);
        add_token(rse_pkg::CMD_END, '0);
        add_token(rse_pkg::CMD_PUSH, FX_MIN);
        add_token(rse_pkg::CMD_PUSH, FX_MAX);
        add_token(rse_pkg::CMD_SUB, '1);
        add_token(rse_pkg::CMD_END, '1);
        // Negative product and negative quotient, both exact.
        add_token(rse_pkg::CMD_PUSH, FX_NEG_1P5);
        add_token(rse_pkg::CMD_PUSH, FX_2P25);
        add_token(rse_pkg::CMD_MUL, '0);
        add_token(rse_pkg::CMD_END, '0);
        add_token(rse_pkg::CMD_PUSH, FX_7);
        add_token(rse_pkg::CMD_PUSH, FX_NEG_2);
        add_token(rse_pkg::CMD_DIV, '0);
        add_token(rse_pkg::CMD_END, '0);
        // Operator on an empty stack.
        add_token(rse_pkg::CMD_ADD, '0);
        add_token(rse_pkg::CMD_END, '0);
        // Division by zero keeps the stack and records the error.
        add_token(rse_pkg::CMD_PUSH, FX_MIN);
        add_token(rse_pkg::CMD_PUSH, '0);
        add_token(rse_pkg::CMD_DIV, '0);
        add_token(rse_pkg::CMD_END, '0);
        // Leftover operands, with ignored commands in between.
        add_token(rse_pkg::CMD_PUSH, FX_ONE);
        add_token(CMD_SPARE_LO, '1);
        add_token(rse_pkg::CMD_PUSH, FX_MIN);
        add_token(CMD_SPARE_HI, '0);
        add_token(rse_pkg::CMD_END, '0);

        // Random part: mostly well-formed expressions, some noise.
        while (queued_tokens < TOKEN_TARGET) begin
            if ($urandom_range(0, 9) < 7) begin
                expr_count++;
                if ($urandom_range(0, 7) == 0)
                    n_vals = $urandom_range(9, rse_pkg::STACK_DEPTH);
                else
                    n_vals = $urandom_range(1, 6);
                add_expression(n_vals, (expr_count % 40) == 0);
            end else
                add_noise();
        end
    endtask

    // Input driver: bursts with random gaps; a token marked drain_first waits
    // until every outstanding result has been received.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (token_taken)
                pending_tokens.delete(0);
            if (!s_tvalid || token_taken) begin
                send_now = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_tokens.size() > 0 &&
                         !(pending_tokens[0].drain_first && results_due.size() > 0)) begin
                    send_now = 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                                 : $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
                s_tvalid <= send_now;
                if (send_now) begin
                    s_tdata <= pending_tokens[0].operand;
                    s_tuser <= pending_tokens[0].cmd;
                end
            end
        end
    end

    // Result receiver: changing ready patterns, plus one long hold-off.
    always @(negedge aclk) begin
        if (!hold_done && results_seen >= 30) begin
            hold_done = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            if (rx_run == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_run = $urandom_range(20, 120);
            end else
                rx_run--;
            case (rx_mode)
                0: ready_now = 1'b1;
                1: ready_now = 1'($urandom_range(0, 1));
                2: ready_now = ($urandom_range(0, 3) == 0);
                default: ready_now = (rx_phase % 3 == 0);
            endcase
            rx_phase++;
            m_tready <= ready_now;
        end
    end

    // Monitor: check results, predict from accepted tokens, and watch for a hang.
    always @(posedge aclk) begin
        token_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_LIMIT)
                        $display("%0t: unexpected result: value %h status %0d",
                                 $time, m_tdata, m_tuser);
                end else begin
                    if (m_tdata !== results_due[0].value ||
                        m_tuser !== results_due[0].status) begin
                        err_count++;
                        if (err_count <= REPORT_LIMIT)
                            $display({"%0t: result mismatch: expected value %h status %0d,",
                                      " got value %h status %0d"},
                                     $time, results_due[0].value, results_due[0].status,
                                     m_tdata, m_tuser);
                    end
                    results_due.delete(0);
                end
            end
            if (s_tvalid && s_tready)
                eval_token(s_tuser, s_tdata);

            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= QUIET_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        build_stimulus();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // Let the stimulus run out, then wait for the last results.
        while (pending_tokens.size() > 0 || s_tvalid)
            @(posedge aclk);
        while (results_due.size() > 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_count == 0 && results_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
